// ===== rtl/core/anxb_pkg.sv =====
package anxb_pkg;

    localparam int COUNT_BITS = 16;
    localparam int TOTAL_BITS = 16;
    localparam int TYPE_BITS  = 5;
    localparam int RUN_BITS   = 2;

    localparam logic [7:0] TYPE_MASK = 8'h1F;
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    localparam logic [TYPE_BITS-1:0] NAL_NON_IDR = 5'd1;
    localparam logic [TYPE_BITS-1:0] NAL_IDR     = 5'd5;

    localparam logic [RUN_BITS-1:0] RUN_MAX       = '1;
    localparam logic [RUN_BITS-1:0] RUN_START_MIN = 2'd2;

    localparam int CMP_BITS = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [TOTAL_BITS-1:0] t_total;

    typedef struct packed {
        logic                 header_seen;
        logic [TYPE_BITS-1:0] nal_type;
    } t_hdr_info;

    typedef struct packed {
        t_total unit_total;
        t_total idr_total;
        logic   key_frame;
    } t_totals;

    function automatic t_count sat_inc(input t_count v);
        sat_inc = (v == COUNT_MAX) ? COUNT_MAX : t_count'(v + 1'b1);
    endfunction

    function automatic t_total clip_total(input t_count v);
        logic [CMP_BITS-1:0] v_ext;
        logic [CMP_BITS-1:0] max_ext;
        v_ext   = CMP_BITS'(v);
        max_ext = CMP_BITS'(TOTAL_MAX);
        clip_total = (v_ext > max_ext) ? TOTAL_MAX : TOTAL_BITS'(v_ext);
    endfunction

endpackage

// ===== rtl/core/anxb_ifs.sv =====
interface anxb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface anxb_result_if;
    logic        valid;
    logic        ready;
    logic        header_seen;
    logic [4:0]  nal_type;
    logic        buffer_done;
    logic [15:0] unit_total;
    logic [15:0] idr_total;
    logic        key_frame;

    modport source (
        output valid, output header_seen, output nal_type, output buffer_done,
        output unit_total, output idr_total, output key_frame, input ready
    );
    modport sink (
        input valid, input header_seen, input nal_type, input buffer_done,
        input unit_total, input idr_total, input key_frame, output ready
    );
endinterface

// ===== rtl/core/anxb_start_detect.sv =====
module anxb_start_detect (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    output anxb_pkg::t_hdr_info o_hdr
);
    import anxb_pkg::*;

    logic [RUN_BITS-1:0] r_zero_run;
    logic [RUN_BITS-1:0] n_zero_run;
    logic                r_expect;
    logic                n_expect;

    always_comb begin
        o_hdr.header_seen = r_expect;
        o_hdr.nal_type    = r_expect ? TYPE_BITS'(i_data_byte & TYPE_MASK) : '0;
        n_expect = (i_data_byte == BYTE_ONE) && (r_zero_run >= RUN_START_MIN);
        if (i_data_byte == BYTE_ZERO) begin
            n_zero_run = (r_zero_run == RUN_MAX) ? RUN_MAX : RUN_BITS'(r_zero_run + 1'b1);
        end else begin
            n_zero_run = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run <= '0;
            r_expect   <= 1'b0;
        end else if (i_step) begin
            if (i_last_byte) begin
                r_zero_run <= '0;
                r_expect   <= 1'b0;
            end else begin
                r_zero_run <= n_zero_run;
                r_expect   <= n_expect;
            end
        end
    end

`ifndef SYNTHESIS
    a_expect_after_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_expect |-> r_zero_run == '0)
        else $error("Start code flag set while a zero run is counted.");
`endif

endmodule

// ===== rtl/core/anxb_stats.sv =====
module anxb_stats (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_last_byte,
    input  anxb_pkg::t_hdr_info i_hdr,
    output anxb_pkg::t_totals   o_totals
);
    import anxb_pkg::*;

    t_count r_units;
    t_count n_units;
    t_count r_idrs;
    t_count n_idrs;
    logic   r_vcl;
    logic   n_vcl;
    logic   r_key;
    logic   n_key;
    logic   is_idr;
    logic   is_vcl;

    always_comb begin
        is_idr  = i_hdr.header_seen && (i_hdr.nal_type == NAL_IDR);
        is_vcl  = i_hdr.header_seen &&
                  ((i_hdr.nal_type == NAL_IDR) || (i_hdr.nal_type == NAL_NON_IDR));
        n_units = i_hdr.header_seen ? sat_inc(r_units) : r_units;
        n_idrs  = is_idr ? sat_inc(r_idrs) : r_idrs;
        n_vcl   = r_vcl || is_vcl;
        n_key   = (!r_vcl && is_vcl) ? is_idr : r_key;
        o_totals.unit_total = clip_total(n_units);
        o_totals.idr_total  = clip_total(n_idrs);
        o_totals.key_frame  = n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_units <= '0;
            r_idrs  <= '0;
            r_vcl   <= 1'b0;
            r_key   <= 1'b0;
        end else if (i_step) begin
            if (i_last_byte) begin
                r_units <= '0;
                r_idrs  <= '0;
                r_vcl   <= 1'b0;
                r_key   <= 1'b0;
            end else begin
                r_units <= n_units;
                r_idrs  <= n_idrs;
                r_vcl   <= n_vcl;
                r_key   <= n_key;
            end
        end
    end

`ifndef SYNTHESIS
    a_key_needs_vcl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key |-> r_vcl)
        else $error("Key-frame flag set before any VCL unit was seen.");

    a_idr_within_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idrs <= r_units)
        else $error("IDR count exceeds unit count.");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last_byte |=> r_units == '0 && r_idrs == '0 && !r_vcl)
        else $error("Buffer statistics not cleared after the last byte.");
`endif

endmodule

// ===== rtl/core/annexb_nal_unit_scanner.sv =====
// Channel   Direction  Payload
// i_in      sink       data_byte[7:0], last_byte
// o_out     source     header_seen, nal_type[4:0], buffer_done, unit_total[15:0],
//                      idr_total[15:0], key_frame
//
// Each byte's result is registered at the transfer edge and offered from the next cycle.
// A new byte is taken in every cycle while the result register is empty or being read.
// A stall on o_out holds the result register and holds off i_in; scan state is untouched.
// Synchronous active-low reset clears the scan state and empties the result register.
module annexb_nal_unit_scanner (
    input  logic          i_clk,
    input  logic          i_rst_n,
    anxb_byte_if.sink     i_in,
    anxb_result_if.source o_out
);
    import anxb_pkg::*;

    logic      step;
    t_hdr_info hdr;
    t_totals   totals;
    logic      r_valid;
    t_hdr_info r_hdr;
    t_totals   r_totals;
    logic      r_done;

    assign i_in.ready = !r_valid || o_out.ready;
    assign step       = i_in.valid && i_in.ready;

    anxb_start_detect u_detect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_hdr       (hdr)
    );

    anxb_stats u_stats (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_last_byte (i_in.last_byte),
        .i_hdr       (hdr),
        .o_totals    (totals)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_hdr    <= hdr;
            r_totals <= totals;
            r_done   <= i_in.last_byte;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.header_seen = r_hdr.header_seen;
    assign o_out.nal_type    = r_hdr.nal_type;
    assign o_out.buffer_done = r_done;
    assign o_out.unit_total  = r_totals.unit_total;
    assign o_out.idr_total   = r_totals.idr_total;
    assign o_out.key_frame   = r_totals.key_frame;

`ifndef SYNTHESIS
    a_type_only_with_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.header_seen |-> o_out.nal_type == '0)
        else $error("NAL type reported without a header.");

    a_header_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.header_seen |-> o_out.unit_total != '0)
        else $error("Header reported but unit total is zero.");
`endif

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import anxb_pkg::*;

    localparam int RANDOM_BYTES = 1500;
    localparam int TAIL_UNITS   = 24;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    // Each word is {last_byte, data_byte}.
    localparam logic [8:0] DIRECTED_BYTES [29] = '{
        9'h000, 9'h000, 9'h001, 9'h065, 9'h000, 9'h000, 9'h001, 9'h141,
        9'h000, 9'h000, 9'h000, 9'h001, 9'h021, 9'h000, 9'h000, 9'h001,
        9'h025, 9'h000, 9'h000, 9'h101,
        9'h009, 9'h000, 9'h000, 9'h001, 9'h000, 9'h000, 9'h001, 9'h1E0,
        9'h1FF
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    typedef struct packed {
        logic                 header_seen;
        logic [TYPE_BITS-1:0] nal_type;
        logic                 buffer_done;
        t_total               unit_total;
        t_total               idr_total;
        logic                 key_frame;
    } scan_report_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    anxb_byte_if   in_if ();
    anxb_result_if out_if ();

    annexb_nal_unit_scanner i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    stream_byte_t byte_q [$];
    scan_report_t report_q [$];

    logic                byte_taken = 1'b0;
    logic                quiet = 1'b0;
    int                  send_gap = 0;
    int                  send_calm = 0;
    int                  recv_gap = 0;
    int                  recv_calm = 0;
    int                  mismatches = 0;
    int                  idle_cycles = 0;

    logic [RUN_BITS-1:0] zeros_seen = '0;
    logic                header_due = 1'b0;
    t_count              units_seen = '0;
    t_count              idrs_seen = '0;
    logic                vcl_found = 1'b0;
    logic                key_pic = 1'b0;

    function automatic t_count bump(input t_count v);
        return (v == COUNT_MAX) ? v : t_count'(v + 1'b1);
    endfunction

    function automatic t_total clip(input t_count v);
        longint unsigned w;
        w = v;
        return (w > TOTAL_MAX) ? TOTAL_MAX : t_total'(w);
    endfunction

    function automatic scan_report_t scan_byte(input logic [7:0] b, input logic last);
        scan_report_t r;
        logic [TYPE_BITS-1:0] kind;
        kind = TYPE_BITS'(b & TYPE_MASK);
        r = '0;
        if (header_due) begin
            r.header_seen = 1'b1;
            r.nal_type = kind;
            units_seen = bump(units_seen);
            if (kind == NAL_IDR) begin
                idrs_seen = bump(idrs_seen);
            end
            if (!vcl_found && (kind == NAL_IDR || kind == NAL_NON_IDR)) begin
                vcl_found = 1'b1;
                key_pic = (kind == NAL_IDR);
            end
        end
        header_due = (b == BYTE_ONE) && (zeros_seen >= RUN_START_MIN);
        if (b != BYTE_ZERO) begin
            zeros_seen = '0;
        end else if (zeros_seen != RUN_MAX) begin
            zeros_seen = zeros_seen + 1'b1;
        end
        r.buffer_done = last;
        r.unit_total = clip(units_seen);
        r.idr_total = clip(idrs_seen);
        r.key_frame = key_pic;
        if (last) begin
            zeros_seen = '0;
            header_due = 1'b0;
            units_seen = '0;
            idrs_seen = '0;
            vcl_found = 1'b0;
            key_pic = 1'b0;
        end
        return r;
    endfunction

    // Returns the length of a new idle burst, or zero; calm stretches have no bursts.
    function automatic int next_gap(inout int calm);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 63) == 0) begin
            calm = $urandom_range(20, 120);
            return 0;
        end
        return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
    endfunction

    function automatic logic [7:0] random_header();
        logic [TYPE_BITS-1:0] kind;
        case ($urandom_range(0, 3))
            0: kind = NAL_IDR;
            1: kind = NAL_NON_IDR;
            default: kind = TYPE_BITS'($urandom_range(0, 31));
        endcase
        return {3'($urandom_range(0, 7)), kind};
    endfunction

    task automatic add_byte(input logic [7:0] d, input logic l);
        byte_q.push_back('{data: d, last: l});
    endtask

    task automatic add_unit(input int zeros, input logic [7:0] hdr, input int body);
        repeat (zeros) add_byte(BYTE_ZERO, 1'b0);
        add_byte(BYTE_ONE, 1'b0);
        add_byte(hdr, 1'b0);
        repeat (body) begin
            add_byte(($urandom_range(0, 3) == 0) ? BYTE_ZERO : 8'($urandom_range(0, 255)),
                     1'b0);
        end
    endtask

    always @(negedge i_clk) begin
        if (byte_taken) begin
            void'(byte_q.pop_front());
        end
        if (!in_if.valid || byte_taken) begin
            if (quiet) begin
                send_gap = 0;
            end else if (send_gap == 0) begin
                send_gap = next_gap(send_calm);
            end
            if (send_gap != 0 || byte_q.size() == 0) begin
                if (send_gap != 0) begin
                    send_gap--;
                end
                in_if.valid <= 1'b0;
            end else begin
                in_if.valid <= 1'b1;
                in_if.data_byte <= byte_q[0].data;
                in_if.last_byte <= byte_q[0].last;
            end
        end
    end

    always @(negedge i_clk) begin
        if (quiet) begin
            recv_gap = 0;
        end else if (recv_gap == 0) begin
            recv_gap = next_gap(recv_calm);
        end
        if (recv_gap != 0) begin
            recv_gap--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        scan_report_t got;
        scan_report_t want;
        logic         out_taken;
        byte_taken = i_rst_n && in_if.valid && in_if.ready;
        out_taken = i_rst_n && out_if.valid && out_if.ready;
        if (out_taken) begin
            got = '{header_seen: out_if.header_seen, nal_type: out_if.nal_type,
                    buffer_done: out_if.buffer_done, unit_total: out_if.unit_total,
                    idr_total: out_if.idr_total, key_frame: out_if.key_frame};
            if (report_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("extra result: hdr=%0d type=%0d done=%0d units=%0d idr=%0d key=%0d",
                             got.header_seen, got.nal_type, got.buffer_done,
                             got.unit_total, got.idr_total, got.key_frame);
                end
            end else begin
                want = report_q.pop_front();
                if (got.header_seen !== want.header_seen || got.nal_type !== want.nal_type ||
                    got.buffer_done !== want.buffer_done ||
                    got.unit_total !== want.unit_total || got.idr_total !== want.idr_total ||
                    got.key_frame !== want.key_frame) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("expected hdr=%0d type=%0d done=%0d units=%0d idr=%0d key=%0d",
                                 want.header_seen, want.nal_type, want.buffer_done,
                                 want.unit_total, want.idr_total, want.key_frame);
                        $display("actual   hdr=%0d type=%0d done=%0d units=%0d idr=%0d key=%0d",
                                 got.header_seen, got.nal_type, got.buffer_done,
                                 got.unit_total, got.idr_total, got.key_frame);
                    end
                end
            end
        end
        if (byte_taken) begin
            report_q.push_back(scan_byte(in_if.data_byte, in_if.last_byte));
        end
        if (byte_taken || out_taken) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int units;
        in_if.valid = 1'b0;
        in_if.data_byte = '0;
        in_if.last_byte = 1'b0;
        out_if.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_BYTES[k]) begin
            add_byte(DIRECTED_BYTES[k][7:0], DIRECTED_BYTES[k][8]);
        end

        while (byte_q.size() < RANDOM_BYTES) begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    add_byte(($urandom_range(0, 1) == 0) ? BYTE_ZERO : BYTE_ONE, 1'b0);
                end
            end
            units = $urandom_range(0, 5);
            repeat (units) begin
                add_unit($urandom_range(2, 5), random_header(), $urandom_range(0, 6));
            end
            case ($urandom_range(0, 3))
                0: add_byte(8'($urandom_range(0, 255)), 1'b1);
                1: begin
                    repeat ($urandom_range(2, 4)) add_byte(BYTE_ZERO, 1'b0);
                    add_byte(BYTE_ONE, 1'b1);
                end
                2: begin
                    add_byte(BYTE_ZERO, 1'b0);
                    add_byte(BYTE_ONE, 1'b0);
                    add_byte(8'($urandom_range(0, 255)), 1'b1);
                end
                default: begin
                    repeat ($urandom_range(2, 4)) add_byte(BYTE_ZERO, 1'b0);
                    add_byte(BYTE_ONE, 1'b0);
                    add_byte(random_header(), 1'b1);
                end
            endcase
        end

        while (byte_q.size() != 0) @(posedge i_clk);
        quiet = 1'b1;

        // A buffer of back-to-back IDR units at full rate, then a short one
        // confirms that the totals start over.
        repeat (TAIL_UNITS) add_unit(2, 8'h65, 0);
        add_byte(8'hAA, 1'b1);
        add_unit(3, 8'h41, 2);
        add_byte(8'($urandom_range(0, 255)), 1'b1);

        while (byte_q.size() != 0 || report_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/anxb_pkg.sv
rtl/core/anxb_ifs.sv
rtl/core/anxb_start_detect.sv
rtl/core/anxb_stats.sv
rtl/core/annexb_nal_unit_scanner.sv
verif/testbench.sv
